// ===== rtl/sswq_pkg.sv =====
package sswq_pkg;

  // field widths of the stream items
  localparam int unsigned IN_ID_W    = 8;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned OUT_ID_W   = 8;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  // tick counter and stored wake times
  localparam int unsigned TIME_W = 64;

  // widest stored sleeper id the block supports
  localparam int unsigned MAX_ID_W = 16;

  // parameter defaults
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ID_WIDTH    = 8;

  // input kinds (tuser) and result kinds (tuser)
  localparam logic MODE_SLEEP  = 1'b0;
  localparam logic MODE_TICK   = 1'b1;
  localparam logic EVT_WOKEN   = 1'b0;
  localparam logic EVT_REJECT  = 1'b1;

endpackage

// ===== rtl/sorted_sleep_wakeup_queue.sv =====
// sorted sleep / wakeup queue
// slave stream s_axis: one beat is either a sleep request (tuser = 0) carrying
// a sleeper id and a duration in tdata, or a timer tick (tuser = 1).
// master stream m_axis: one beat per result; tuser = 0 for a woken sleeper,
// 1 for a request rejected because the queue is full; tdata holds the id and
// tlast marks the final result caused by one input beat.
// the queue is a circular buffer in one ram; a single 64-bit comparator is
// shared by insertion and draining under a small sequencer, and s_axis_tready
// is high only while the sequencer is idle.
// sleep request: each queued entry with a later wake time is read and then
// moved one place towards the tail (one ram read and one write each) until an
// entry keeps its place. zero duration: no entry and no result. rejection:
// one result. tick: due entries are popped from the head, each woken sleeper
// reported, the last with tlast; each step waits on the ram's registered
// read port.
// results leave through an output register: a stalled receiver holds the
// sequencer where it must emit, nothing is dropped.
// reset empties the queue and clears the tick count.
module sorted_sleep_wakeup_queue #(
  parameter int unsigned QUEUE_DEPTH = sswq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_WIDTH    = sswq_pkg::DEF_ID_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sswq_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // sleeper_id[7:0], duration[39:8]
  input  logic [0:0]                      s_axis_tuser,   // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sswq_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // woken_id[7:0]
  output logic [0:0]                      m_axis_tuser,   // event_kind
  output logic                            m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned ENT_W = sswq_pkg::TIME_W + ID_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_POP_RD,
    ST_POP_CMP,
    ST_FLUSH,
    ST_REJ
  } state_t;

  state_t                         state;
  logic [sswq_pkg::TIME_W-1:0]    tick_count;
  logic [IDX_W-1:0]               head;
  logic [CNT_W-1:0]               count;
  logic [IDX_W-1:0]               pos;
  logic [CNT_W-1:0]               remain;
  logic [sswq_pkg::TIME_W-1:0]    when_t;
  logic [ID_WIDTH-1:0]            new_id;
  logic [sswq_pkg::IN_ID_W-1:0]   rej_id;
  logic                           pend_valid;
  logic [ID_WIDTH-1:0]            pend_id;
  logic [IDX_W-1:0]               raddr_q;

  logic                           in_fire;
  logic                           out_free;
  logic                           out_load;
  logic [sswq_pkg::IN_ID_W-1:0]   in_id;
  logic [sswq_pkg::DUR_W-1:0]     in_dur;
  logic [sswq_pkg::MAX_ID_W-1:0]  in_id_ext;
  logic [sswq_pkg::MAX_ID_W-1:0]  pend_id_ext;
  logic [SUM_W-1:0]               tail_sum;
  logic [IDX_W-1:0]               tail;
  logic [IDX_W-1:0]               pos_prev;
  logic [IDX_W-1:0]               head_nx;
  logic [IDX_W-1:0]               rd_addr;
  logic [ENT_W-1:0]               rd_data;
  logic [sswq_pkg::TIME_W-1:0]    rd_wake;
  logic [ID_WIDTH-1:0]            rd_id;
  logic                           rd_le_when;
  logic                           rd_due;
  logic                           we;
  logic [IDX_W-1:0]               waddr;
  logic [ENT_W-1:0]               wdata;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign in_id         = s_axis_tdata[sswq_pkg::IN_ID_W-1:0];
  assign in_dur        = s_axis_tdata[sswq_pkg::IN_DATA_W-1:sswq_pkg::IN_ID_W];
  assign in_id_ext     = sswq_pkg::MAX_ID_W'(in_id);
  assign pend_id_ext   = sswq_pkg::MAX_ID_W'(pend_id);
  assign rd_wake       = rd_data[sswq_pkg::TIME_W-1:0];
  assign rd_id         = rd_data[ENT_W-1:sswq_pkg::TIME_W];

  always_comb begin
    // tail slot = (head + count) mod depth
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];

    pos_prev = (pos == '0) ? IDX_W'(QUEUE_DEPTH - 1) : pos - 1'b1;
    head_nx  = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

    case (state)
      ST_POP_RD: rd_addr = head;
      ST_INS_RD: rd_addr = pos_prev;
      default:   rd_addr = raddr_q;
    endcase

    // the one shared comparator
    rd_le_when = (rd_wake <= ((state == ST_INS_CMP) ? when_t : tick_count));
    rd_due     = rd_le_when;

    // a new beat enters the output register
    case (state)
      ST_POP_CMP:      out_load = rd_due && pend_valid && out_free;
      ST_FLUSH, ST_REJ: out_load = out_free;
      default:         out_load = 1'b0;
    endcase

    we    = 1'b0;
    waddr = pos;
    wdata = {new_id, when_t};
    case (state)
      ST_INS_RD: begin
        we = (remain == '0);
      end
      ST_INS_CMP: begin
        we = 1'b1;
        // a later wake time moves one slot towards the tail
        if (!rd_le_when) begin
          wdata = rd_data;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  sswq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    raddr_q <= rd_addr;
    if (rst) begin
      state         <= ST_IDLE;
      tick_count    <= '0;
      head          <= '0;
      count         <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser[0] == sswq_pkg::MODE_TICK) begin
              tick_count <= tick_count + 1'b1;
              state      <= ST_POP_RD;
            end else if (in_dur == '0) begin
              state <= ST_IDLE;
            end else if (count == CNT_W'(QUEUE_DEPTH)) begin
              rej_id <= in_id;
              state  <= ST_REJ;
            end else begin
              when_t <= tick_count + sswq_pkg::TIME_W'(in_dur);
              new_id <= in_id_ext[ID_WIDTH-1:0];
              pos    <= tail;
              remain <= count;
              state  <= ST_INS_RD;
            end
          end
        end
        ST_INS_RD: begin
          if (remain == '0) begin
            count <= count + 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (rd_le_when) begin
            count <= count + 1'b1;
            state <= ST_IDLE;
          end else begin
            pos    <= pos_prev;
            remain <= remain - 1'b1;
            state  <= ST_INS_RD;
          end
        end
        ST_POP_RD: begin
          if (count == '0) begin
            state <= pend_valid ? ST_FLUSH : ST_IDLE;
          end else begin
            state <= ST_POP_CMP;
          end
        end
        ST_POP_CMP: begin
          if (rd_due) begin
            // one popped entry is held back until we know whether it is last
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                m_axis_tdata  <= pend_id_ext[sswq_pkg::OUT_ID_W-1:0];
                m_axis_tuser  <= sswq_pkg::EVT_WOKEN;
                m_axis_tlast  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_id    <= rd_id;
              head       <= head_nx;
              count      <= count - 1'b1;
              state      <= ST_POP_RD;
            end
          end else begin
            state <= pend_valid ? ST_FLUSH : ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            m_axis_tdata  <= pend_id_ext[sswq_pkg::OUT_ID_W-1:0];
            m_axis_tuser  <= sswq_pkg::EVT_WOKEN;
            m_axis_tlast  <= 1'b1;
            pend_valid    <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        ST_REJ: begin
          if (out_free) begin
            m_axis_tdata  <= rej_id;
            m_axis_tuser  <= sswq_pkg::EVT_REJECT;
            m_axis_tlast  <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> (count == $past(count) + 1'b1) ||
                              (count == $past(count) - 1'b1))
    else $error("occupancy moved by more than one");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("woken sleeper left unreported");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == sswq_pkg::EVT_REJECT) |-> m_axis_tlast)
    else $error("rejection beat without tlast");

endmodule

// ===== rtl/sswq_ram.sv =====
module sswq_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
